FILE: hdl/scs_pkg.sv
package scs_pkg;

	// Default search range of the calibration points.
	localparam int POS_RANGE_DEF = 256;

	// Q1.16 constants
	localparam int QW         = 17;
	localparam int LEVEL_SH   = 10;
	localparam logic [QW-1:0] Q_ONE  = QW'(65536);
	localparam logic [QW-1:0] Q_NEAR = QW'(256);
	localparam logic [15:0]   NEAR_LIMIT = 16'(65536 - 256);

	localparam logic [7:0] PICK_LO_NONE = 8'hFF;
	localparam logic [7:0] PICK_HI_NONE = 8'h00;

	// Divider: one quotient bit per step.
	localparam int DIV_STEPS = 16;
	localparam int CW        = $clog2(DIV_STEPS);
	typedef logic [CW-1:0] cnt_t;
	localparam cnt_t DIV_LAST = cnt_t'(DIV_STEPS - 1);

	typedef struct packed {
		logic [7:0] slider_pos;
		logic [6:0] target_level;
	} req_t;

	typedef struct packed {
		logic [7:0] cal_low;
		logic [7:0] cal_high;
	} rsp_t;

	// Microcode step address
	typedef logic [3:0] upc_t;
	localparam upc_t U_IDLE     = 4'd0;
	localparam upc_t U_CHECK    = 4'd1;
	localparam upc_t U_HI_INIT  = 4'd2;
	localparam upc_t U_DIV_INIT = 4'd3;
	localparam upc_t U_DIV_STEP = 4'd4;
	localparam upc_t U_EVAL     = 4'd5;
	localparam upc_t U_NEXT_HI  = 4'd6;
	localparam upc_t U_NEXT_LO  = 4'd7;
	localparam upc_t U_OUT      = 4'd8;
	localparam upc_t U_LAST     = U_OUT;

	typedef enum logic [3:0] {
		ACT_NONE     = 4'd0,
		ACT_LOAD     = 4'd1,
		ACT_HI_INIT  = 4'd2,
		ACT_DIV_INIT = 4'd3,
		ACT_DIV_STEP = 4'd4,
		ACT_EVAL     = 4'd5,
		ACT_NEXT_HI  = 4'd6,
		ACT_NEXT_LO  = 4'd7,
		ACT_OUT      = 4'd8
	} act_t;

	typedef enum logic [3:0] {
		COND_NEVER    = 4'd0,
		COND_WAIT_IN  = 4'd1,
		COND_SKIP     = 4'd2,
		COND_BIG      = 4'd3,
		COND_DIV_MORE = 4'd4,
		COND_NEAR_HIT = 4'd5,
		COND_HI_MORE  = 4'd6,
		COND_LO_MORE  = 4'd7,
		COND_OUT_BUSY = 4'd8
	} cond_t;

	typedef struct packed {
		act_t  act;
		cond_t cond;
		upc_t  tgt_true;
		upc_t  tgt_false;
	} ucode_t;

	// Datapath flags seen by the branch logic
	typedef struct packed {
		logic wait_in;
		logic skip;
		logic big;
		logic div_more;
		logic near_hit;
		logic hi_more;
		logic lo_more;
		logic out_busy;
	} stat_t;

	// Control store
	function automatic ucode_t ucode_rom(input upc_t a);
		ucode_t w;
		unique case (a)
			U_IDLE:     w = '{ACT_LOAD,     COND_WAIT_IN,  U_IDLE,     U_CHECK};
			U_CHECK:    w = '{ACT_NONE,     COND_SKIP,     U_OUT,      U_HI_INIT};
			U_HI_INIT:  w = '{ACT_HI_INIT,  COND_NEVER,    U_DIV_INIT, U_DIV_INIT};
			U_DIV_INIT: w = '{ACT_DIV_INIT, COND_BIG,      U_EVAL,     U_DIV_STEP};
			U_DIV_STEP: w = '{ACT_DIV_STEP, COND_DIV_MORE, U_DIV_STEP, U_EVAL};
			U_EVAL:     w = '{ACT_EVAL,     COND_NEAR_HIT, U_NEXT_LO,  U_NEXT_HI};
			U_NEXT_HI:  w = '{ACT_NEXT_HI,  COND_HI_MORE,  U_DIV_INIT, U_NEXT_LO};
			U_NEXT_LO:  w = '{ACT_NEXT_LO,  COND_LO_MORE,  U_HI_INIT,  U_OUT};
			U_OUT:      w = '{ACT_OUT,      COND_OUT_BUSY, U_OUT,      U_IDLE};
			default:    w = '{ACT_NONE,     COND_NEVER,    U_IDLE,     U_IDLE};
		endcase
		return w;
	endfunction

endpackage

FILE: hdl/scs_useq.sv
module scs_useq (
	input  logic           clk,
	input  logic           arst_n,
	input  scs_pkg::stat_t stat,
	output scs_pkg::act_t  act
);

	scs_pkg::upc_t   upc_q;
	scs_pkg::ucode_t word;
	logic            take;

	assign word = scs_pkg::ucode_rom(upc_q);
	assign act  = word.act;

	always_comb begin
		case (word.cond)
			scs_pkg::COND_NEVER:    take = 1'b0;
			scs_pkg::COND_WAIT_IN:  take = stat.wait_in;
			scs_pkg::COND_SKIP:     take = stat.skip;
			scs_pkg::COND_BIG:      take = stat.big;
			scs_pkg::COND_DIV_MORE: take = stat.div_more;
			scs_pkg::COND_NEAR_HIT: take = stat.near_hit;
			scs_pkg::COND_HI_MORE:  take = stat.hi_more;
			scs_pkg::COND_LO_MORE:  take = stat.lo_more;
			scs_pkg::COND_OUT_BUSY: take = stat.out_busy;
			default:                take = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= scs_pkg::U_IDLE;
		end else begin
			upc_q <= take ? word.tgt_true : word.tgt_false;
		end
	end

	a_upc_range: assert property (@(posedge clk) disable iff (!arst_n)
		upc_q <= scs_pkg::U_LAST)
		else $error("step counter left the program");

	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(upc_q == scs_pkg::U_IDLE && !stat.wait_in) |=> (upc_q == scs_pkg::U_CHECK))
		else $error("accepted transaction did not start the search");

	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		(upc_q == scs_pkg::U_DIV_STEP && !stat.div_more) |=> (upc_q == scs_pkg::U_EVAL))
		else $error("divider did not hand over to evaluation");

endmodule

FILE: hdl/scs_datapath.sv
module scs_datapath #(
	parameter int POS_RANGE = scs_pkg::POS_RANGE_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  scs_pkg::act_t  act,
	output scs_pkg::stat_t stat,
	input  logic           req_valid,
	output logic           req_stall,
	input  scs_pkg::req_t  req_data,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output scs_pkg::rsp_t  rsp_data
);

	localparam int HW = $clog2(POS_RANGE);
	localparam int EW = (HW > 8) ? HW : 8;
	localparam int QW = scs_pkg::QW;

	logic [7:0]    pos_q;
	logic [QW-1:0] level_q;
	logic [7:0]    lo_q;
	logic [HW-1:0] hi_q;
	logic [HW-1:0] den_q;
	logic [HW-1:0] rem_q;
	logic [15:0]   quo_q;
	scs_pkg::cnt_t cnt_q;
	logic          one_q;
	logic [QW-1:0] best_q;
	logic [7:0]    pick_lo_q;
	logic [7:0]    pick_hi_q;
	logic          rsp_valid_q;
	scs_pkg::rsp_t rsp_q;

	logic [EW-1:0] hi_e, lo_e, pos_e, den_n, rem_n;
	logic [HW:0]   rem_sh, trial;
	logic          trial_ok;
	logic [QW-1:0] ratio;
	logic [QW:0]   diff;
	logic          hit, near;

	assign hi_e  = EW'(hi_q);
	assign lo_e  = EW'(lo_q);
	assign pos_e = EW'(pos_q);
	assign den_n = hi_e - lo_e;
	assign rem_n = pos_e - lo_e;

	// restoring divide step
	assign rem_sh   = {rem_q, 1'b0};
	assign trial_ok = rem_sh >= {1'b0, den_q};
	assign trial    = rem_sh - {1'b0, den_q};

	// ratio snaps to one when within 1/256 of it
	assign ratio = (one_q || quo_q >= scs_pkg::NEAR_LIMIT) ? scs_pkg::Q_ONE : {1'b0, quo_q};
	assign diff  = {1'b0, level_q} - {1'b0, ratio};
	assign hit   = !diff[QW] && (diff[QW-1:0] <= best_q);
	assign near  = hit && (diff[QW-1:0] < scs_pkg::Q_NEAR);

	assign stat.wait_in  = !req_valid;
	assign stat.skip     = (pos_q == 8'd0) || (32'(pos_q) >= 32'(POS_RANGE));
	assign stat.big      = (hi_e == pos_e);
	assign stat.div_more = (cnt_q != scs_pkg::DIV_LAST);
	assign stat.near_hit = near;
	assign stat.hi_more  = (hi_q != HW'(POS_RANGE - 1));
	assign stat.lo_more  = (lo_q != pos_q - 8'd1);
	assign stat.out_busy = rsp_valid_q && rsp_stall;

	assign req_stall = (act != scs_pkg::ACT_LOAD);
	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	always_ff @(posedge clk) begin
		case (act)
			scs_pkg::ACT_LOAD: begin
				if (req_valid) begin
					pos_q     <= req_data.slider_pos;
					level_q   <= {req_data.target_level, scs_pkg::LEVEL_SH'(0)};
					best_q    <= scs_pkg::Q_ONE;
					pick_lo_q <= scs_pkg::PICK_LO_NONE;
					pick_hi_q <= scs_pkg::PICK_HI_NONE;
					lo_q      <= 8'd0;
				end
			end
			scs_pkg::ACT_HI_INIT: begin
				hi_q <= pos_e[HW-1:0];
			end
			scs_pkg::ACT_DIV_INIT: begin
				den_q <= den_n[HW-1:0];
				rem_q <= rem_n[HW-1:0];
				quo_q <= '0;
				cnt_q <= '0;
				one_q <= (hi_e == pos_e);
			end
			scs_pkg::ACT_DIV_STEP: begin
				if (trial_ok) begin
					rem_q <= trial[HW-1:0];
				end else begin
					rem_q <= rem_sh[HW-1:0];
				end
				quo_q <= {quo_q[14:0], trial_ok};
				cnt_q <= cnt_q + scs_pkg::cnt_t'(1);
			end
			scs_pkg::ACT_EVAL: begin
				if (hit) begin
					best_q    <= diff[QW-1:0];
					pick_lo_q <= lo_q;
					pick_hi_q <= hi_e[7:0];
				end
			end
			scs_pkg::ACT_NEXT_HI: begin
				hi_q <= hi_q + HW'(1);
			end
			scs_pkg::ACT_NEXT_LO: begin
				lo_q <= lo_q + 8'd1;
			end
			scs_pkg::ACT_OUT: begin
				if (!stat.out_busy) begin
					rsp_q.cal_low  <= pick_lo_q;
					rsp_q.cal_high <= pick_hi_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (act == scs_pkg::ACT_OUT && !stat.out_busy) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_valid_q && !rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		(act == scs_pkg::ACT_DIV_STEP) |-> (rem_q < den_q))
		else $error("divider remainder not below divisor");

	a_best_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(act == scs_pkg::ACT_EVAL && hit) |=> (best_q <= $past(best_q)))
		else $error("best difference grew");

	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		(act == scs_pkg::ACT_OUT && !stat.out_busy) |=> rsp_valid_q)
		else $error("result not presented after output step");

endmodule

FILE: hdl/slider_calibration_search.sv
// Channel   Dir  Payload                          Transaction when
// req       in   scs_pkg::req_t (slider, level)   req_valid && !req_stall
// rsp       out  scs_pkg::rsp_t (low, high)       rsp_valid && !rsp_stall
//
// Flow: one request at a time. Each (low, high) pair runs setup, the divide steps,
//   evaluate and advance, or skips the divide steps when high equals the slider;
//   each low adds a high-init and a low-advance step. Worst case is near slider 128
//   with range 256, set by the single shared restoring divider, one quotient bit per cycle.
// Reset: arst_n clears the step counter and the result valid; no clearing pass.
// Stalls: rsp_stall holds the result register; the sequencer waits in its output step.
module slider_calibration_search #(
	parameter int POS_RANGE = scs_pkg::POS_RANGE_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  scs_pkg::req_t req_data,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output scs_pkg::rsp_t rsp_data
);

	// Control flows from the microcoded sequencer to the datapath as one
	// action per step; the datapath returns its branch flags.
	scs_pkg::act_t  act;
	scs_pkg::stat_t stat;

	scs_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.act    (act)
	);

	// Holds the request, the low/high counters, the divider, the best
	// difference so far and the result register.
	scs_datapath #(
		.POS_RANGE (POS_RANGE)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.act       (act),
		.stat      (stat),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data)
	);

endmodule

FILE: tb/sv/calib_pair_checker.sv
`timescale 1ns / 100ps

module calib_pair_checker (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  logic          req_stall,
	input  scs_pkg::req_t req_data,
	input  logic          rsp_valid,
	input  logic          rsp_stall,
	input  scs_pkg::rsp_t rsp_data,
	output int            mismatches,
	output int            pairs_due
);

	scs_pkg::rsp_t pair_q[$];
	int            fails = 0;
	int            due   = 0;

	assign mismatches = fails;
	assign pairs_due  = due;

	// (low, high) scan, low outer, high inner, both ascending; a near hit ends the high scan.
	function automatic scs_pkg::rsp_t closest_pair(input scs_pkg::req_t rq);
		int unsigned   pos;
		int unsigned   lo;
		int unsigned   hi;
		int unsigned   ratio;
		longint        level;
		longint        best;
		longint        diff;
		scs_pkg::rsp_t pick;
		pos           = rq.slider_pos;
		level         = longint'(rq.target_level) << scs_pkg::LEVEL_SH;
		best          = longint'(scs_pkg::Q_ONE);
		pick.cal_low  = scs_pkg::PICK_LO_NONE;
		pick.cal_high = scs_pkg::PICK_HI_NONE;
		if (pos != 0 && pos < scs_pkg::POS_RANGE_DEF) begin
			for (lo = 0; lo < pos; lo++) begin
				for (hi = pos; hi < scs_pkg::POS_RANGE_DEF; hi++) begin
					// Q0.16 truncated; within 1/256 of one snaps to one
					ratio = ((pos - lo) << 16) / (hi - lo);
					if (ratio + scs_pkg::Q_NEAR >= scs_pkg::Q_ONE)
						ratio = scs_pkg::Q_ONE;
					diff = level - longint'(ratio);
					if (diff < 0 || diff > best)
						continue;
					best          = diff;
					pick.cal_low  = lo[7:0];
					pick.cal_high = hi[7:0];
					if (diff < longint'(scs_pkg::Q_NEAR))
						break;
				end
			end
		end
		return pick;
	endfunction

	always @(posedge clk) begin : watch
		scs_pkg::rsp_t want;
		if (arst_n) begin
			if (req_valid && !req_stall)
				pair_q.push_back(closest_pair(req_data));
			if (rsp_valid && !rsp_stall) begin
				if (pair_q.size() == 0) begin
					$error("result with none pending: cal_low=%0d cal_high=%0d",
						rsp_data.cal_low, rsp_data.cal_high);
					fails++;
				end else begin
					want = pair_q.pop_front();
					if (rsp_data.cal_low !== want.cal_low) begin
						$error("cal_low: expected %0d, actual %0d",
							want.cal_low, rsp_data.cal_low);
						fails++;
					end
					if (rsp_data.cal_high !== want.cal_high) begin
						$error("cal_high: expected %0d, actual %0d",
							want.cal_high, rsp_data.cal_high);
						fails++;
					end
				end
			end
		end
		due <= pair_q.size();
	end

endmodule

FILE: tb/sv/slider_calibration_search_tb.sv
`timescale 1ns / 100ps

module slider_calibration_search_tb;

	// A slider near mid-range gives the longest search, with no transaction;
	// the limit is chosen to exceed it.
	localparam int QUIET_LIMIT    = 1_200_000;
	// Quiet time after the last result, to catch a stray extra one.
	localparam int DRAIN_CYCLES   = 100;
	localparam int RAND_PER_PHASE = 28;

	logic          clk       = 1'b0;
	logic          arst_n    = 1'b0;
	logic          req_valid = 1'b0;
	logic          req_stall;
	scs_pkg::req_t req_data  = '0;
	logic          rsp_valid;
	logic          rsp_stall = 1'b0;
	scs_pkg::rsp_t rsp_data;

	// Idle odds in percent; sender odds are read only by the stimulus process.
	int snd_idle_pct = 13;
	int rcv_idle_pct = 76;
	int quiet_cycles = 0;
	int mismatches;
	int pairs_due;

	slider_calibration_search uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data)
	);

	calib_pair_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req_data   (req_data),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp_data   (rsp_data),
		.mismatches (mismatches),
		.pairs_due  (pairs_due)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Result side: random back-pressure, redrawn every cycle.
	always @(posedge clk) begin
		rsp_stall <= arst_n && ($urandom_range(99) < rcv_idle_pct);
	end

	// Watchdog: any transaction on either channel restarts the count.
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// One request transaction. Valid stays high after acceptance; the next call
	// drops it only if it draws an idle gap, so it never toggles within a step.
	task automatic send_req(input logic [7:0] pos, input logic [6:0] lvl);
		while ($urandom_range(99) < snd_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req_data  <= '{slider_pos: pos, target_level: lvl};
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
	endtask

	// Sender holds off until every predicted pair has come back.
	task automatic wait_all_results();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pairs_due != 0)
			@(posedge clk);
	endtask

	// Search cost grows with slider * (range - slider), so most draws sit at
	// the ends of the range where a request finishes quickly.
	// Zero and 255 together toggle every bit; 1 and 2 cover the low bits.
	function automatic logic [7:0] rand_slider();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 12)
			return 8'd0;
		else if (roll < 30)
			return 8'd255;
		else if (roll < 48)
			return 8'd254;
		else if (roll < 64)
			return 8'd1;
		else if (roll < 80)
			return 8'd2;
		else if (roll < 90)
			return 8'($urandom_range(4, 3));
		else
			return 8'($urandom_range(253, 251));
	endfunction

	// Mostly legal levels 0..64; some above 64, which the block takes as given.
	function automatic logic [6:0] rand_level();
		if ($urandom_range(99) < 85)
			return 7'($urandom_range(64, 0));
		else
			return 7'($urandom_range(127, 65));
	endfunction

	task automatic random_phase(input int snd_pct, input int rcv_pct);
		int n;
		// Phase change only with the block drained.
		wait_all_results();
		snd_idle_pct = snd_pct;
		rcv_idle_pct <= rcv_pct;
		for (n = 0; n < RAND_PER_PHASE; n++)
			send_req(rand_slider(), rand_level());
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: slider at zero gives the empty pair whatever the level.
		send_req(8'd0, 7'd0);
		send_req(8'd0, 7'd64);
		send_req(8'd0, 7'd127);
		// Slider at the top: only high = 255, ratio is always one.
		send_req(8'd255, 7'd0);
		send_req(8'd255, 7'd64);
		send_req(8'd255, 7'd127);
		send_req(8'd254, 7'd96);
		// Level zero never accepts a pair (diff is never >= 0 and kept).
		send_req(8'd1, 7'd0);
		send_req(8'd1, 7'd1);
		send_req(8'd1, 7'd64);
		send_req(8'd2, 7'd32);
		send_req(8'd2, 7'd127);
		send_req(8'd3, 7'd63);
		send_req(8'd253, 7'd48);
		// One mid-range slider with a level above one: no early exit, full scan.
		send_req(8'd128, 7'd85);

		random_phase(13, 76);
		random_phase(76, 13);
		random_phase(0, 0);

		wait_all_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
